// File: rtl/block_link_receiver_core_assert.svh
// Assertion macros for the block link receiver
`ifndef BLOCK_LINK_RECEIVER_CORE_ASSERT_SVH
`define BLOCK_LINK_RECEIVER_CORE_ASSERT_SVH

// check a consequence in the same cycle
`define BLR_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("block link receiver assertion failed");

// check a consequence in the next cycle
`define BLR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("block link receiver assertion failed");

`endif

// File: rtl/blr_pkg.sv
// Types and constants for the block link receiver
`timescale 1ns / 1ps

package blr_pkg;

    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_BYTE  = 2'd1;
    localparam logic [1:0] OP_ABORT = 2'd2;

    localparam logic [1:0] KIND_TX     = 2'd0;
    localparam logic [1:0] KIND_STORE  = 2'd1;
    localparam logic [1:0] KIND_FINISH = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_CONN = 2'd1;
    localparam logic [1:0] ST_HAND = 2'd2;

    localparam logic [7:0] CFG_MAX_BUFFER     = 8'd0;
    localparam logic [7:0] CFG_READY_CODE     = 8'd1;
    localparam logic [7:0] CFG_READY_ACK_CODE = 8'd2;
    localparam logic [7:0] CFG_SUCCESS_CODE   = 8'd3;

    localparam logic [15:0] MAX_BUFFER_RESET = 16'd8192;
    localparam int          MAX_RESULTS      = 3;

    typedef enum logic [3:0] {
        PH_IDLE  = 4'd0,
        PH_ACK0  = 4'd1,
        PH_HDR   = 4'd2,
        PH_LENLO = 4'd3,
        PH_LENHI = 4'd4,
        PH_IDX   = 4'd5,
        PH_PAY   = 4'd6,
        PH_CHK   = 4'd7,
        PH_ACK1  = 4'd8
    } blr_phase_t;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] rx_byte;
    } blr_in_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  value;
        logic [15:0] address;
        logic [1:0]  status;
        logic [15:0] total_size;
        logic        last;
    } blr_out_t;

    typedef struct packed {
        logic [15:0] max_buffer;
        logic [7:0]  ready_code;
        logic [7:0]  ready_ack_code;
        logic [7:0]  success_code;
    } blr_cfg_t;

    typedef struct packed {
        blr_phase_t  phase;
        logic [15:0] committed_offset;
        logic [7:0]  expected_index;
        logic [15:0] block_length;
        logic [15:0] payload_count;
        logic [15:0] running_sum;
        logic [7:0]  header_code;
    } blr_state_t;

    function automatic blr_out_t blr_result(logic [1:0] kind, logic [7:0] value,
                                            logic [15:0] address, logic [1:0] status,
                                            logic [15:0] total_size);
        blr_out_t r;
        r.kind       = kind;
        r.value      = value;
        r.address    = address;
        r.status     = status;
        r.total_size = total_size;
        r.last       = 1'b0;
        return r;
    endfunction

endpackage

// File: rtl/blr_step.sv
// Next-state and result logic for one received word
`timescale 1ns / 1ps

module blr_step
    import blr_pkg::*;
(
    input  blr_state_t                 cur,
    input  blr_cfg_t                   cfg,
    input  blr_in_t                    item,
    output blr_state_t                 nxt,
    output logic [1:0]                 res_cnt,
    output blr_out_t [MAX_RESULTS-1:0] res
);

    logic [16:0] end_offset;
    logic [15:0] count_inc;
    logic [7:0]  local_sum;
    blr_out_t    finish_conn;
    blr_out_t    finish_hand;

    assign end_offset  = {1'b0, cur.committed_offset} + {1'b0, cur.block_length};
    assign count_inc   = cur.payload_count + 16'd1;
    assign local_sum   = cur.running_sum[7:0] + cur.running_sum[15:8];
    assign finish_conn = blr_result(KIND_FINISH, 8'd0, 16'd0, ST_CONN, 16'd0);
    assign finish_hand = blr_result(KIND_FINISH, 8'd0, 16'd0, ST_HAND, 16'd0);

    always_comb
    begin
        nxt     = cur;
        res_cnt = 2'd0;
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            res[i] = blr_result(KIND_TX, 8'd0, 16'd0, ST_OK, 16'd0);
        end

        case (item.op)
            OP_START:
            begin
                nxt.committed_offset = 16'd0;
                nxt.expected_index   = 8'd0;
                nxt.block_length     = 16'd0;
                nxt.payload_count    = 16'd0;
                nxt.running_sum      = 16'd0;
                nxt.header_code      = 8'd0;
                nxt.phase            = PH_ACK0;
                res[0]  = blr_result(KIND_TX, cfg.ready_code, 16'd0, ST_OK, 16'd0);
                res_cnt = 2'd1;
            end
            OP_ABORT:
            begin
                if (cur.phase == PH_ACK0 || cur.phase == PH_ACK1)
                begin
                    res[0]    = finish_hand;
                    res_cnt   = 2'd1;
                    nxt.phase = PH_IDLE;
                end
                else if (cur.phase != PH_IDLE)
                begin
                    res[0]    = finish_conn;
                    res_cnt   = 2'd1;
                    nxt.phase = PH_IDLE;
                end
            end
            OP_BYTE:
            begin
                case (cur.phase)
                    PH_ACK0:
                    begin
                        if (item.rx_byte == cfg.ready_ack_code)
                        begin
                            res[0] = blr_result(KIND_TX, cfg.max_buffer[7:0], 16'd0,
                                                ST_OK, 16'd0);
                            res[1] = blr_result(KIND_TX, cfg.max_buffer[15:8], 16'd0,
                                                ST_OK, 16'd0);
                            res_cnt   = 2'd2;
                            nxt.phase = PH_HDR;
                        end
                        else
                        begin
                            res[0]  = blr_result(KIND_TX, cfg.ready_code, 16'd0,
                                                 ST_OK, 16'd0);
                            res_cnt = 2'd1;
                        end
                    end
                    PH_HDR:
                    begin
                        nxt.header_code = item.rx_byte;
                        nxt.phase       = PH_LENLO;
                    end
                    PH_LENLO:
                    begin
                        nxt.block_length = {8'd0, item.rx_byte};
                        nxt.phase        = PH_LENHI;
                    end
                    PH_LENHI:
                    begin
                        nxt.block_length = {item.rx_byte, cur.block_length[7:0]};
                        nxt.phase        = PH_IDX;
                    end
                    PH_IDX:
                    begin
                        if (item.rx_byte != cur.expected_index
                            || end_offset > {1'b0, cfg.max_buffer})
                        begin
                            res[0]    = finish_conn;
                            res_cnt   = 2'd1;
                            nxt.phase = PH_IDLE;
                        end
                        else
                        begin
                            nxt.running_sum   = 16'd0;
                            nxt.payload_count = 16'd0;
                            nxt.phase = (cur.block_length == 16'd0) ? PH_CHK : PH_PAY;
                        end
                    end
                    PH_PAY:
                    begin
                        res[0] = blr_result(KIND_STORE, item.rx_byte,
                                            cur.committed_offset + cur.payload_count,
                                            ST_OK, 16'd0);
                        res_cnt           = 2'd1;
                        nxt.running_sum   = cur.running_sum + {8'd0, item.rx_byte};
                        nxt.payload_count = count_inc;
                        if (count_inc == cur.block_length)
                        begin
                            nxt.phase = PH_CHK;
                        end
                    end
                    PH_CHK:
                    begin
                        res[0]  = blr_result(KIND_TX, local_sum, 16'd0, ST_OK, 16'd0);
                        res_cnt = 2'd1;
                        if (item.rx_byte != local_sum)
                        begin
                            nxt.phase = PH_HDR;
                        end
                        else
                        begin
                            nxt.committed_offset = cur.committed_offset + cur.block_length;
                            nxt.expected_index   = cur.expected_index + 8'd1;
                            res[1] = blr_result(KIND_TX, cfg.ready_code, 16'd0,
                                                ST_OK, 16'd0);
                            res[2] = blr_result(KIND_TX, cfg.success_code, 16'd0,
                                                ST_OK, 16'd0);
                            res_cnt   = 2'd3;
                            nxt.phase = PH_ACK1;
                        end
                    end
                    PH_ACK1:
                    begin
                        if (item.rx_byte != cfg.ready_ack_code)
                        begin
                            res[0]    = finish_hand;
                            res_cnt   = 2'd1;
                            nxt.phase = PH_IDLE;
                        end
                        else if (cur.header_code == cfg.success_code)
                        begin
                            res[0]    = blr_result(KIND_FINISH, 8'd0, 16'd0, ST_OK,
                                                   cur.committed_offset);
                            res_cnt   = 2'd1;
                            nxt.phase = PH_IDLE;
                        end
                        else
                        begin
                            nxt.phase = PH_HDR;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            default:
            begin
            end
        endcase

        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            res[i].last = (2'(i + 1) == res_cnt);
        end
    end

endmodule

// File: rtl/block_link_receiver_core.sv
// Block link receiver top level: state, config registers and result queue
// The first result of a word is registered and appears in the cycle after the word is accepted.
// A word causes zero to three results, delivered in order, one per cycle while out_ready is high.
// Throughput: one word per cycle while each word causes at most one result and out_ready is high;
// a new word is taken while the last result of the previous one is taken, so the rate is set by the result count.
// Reset: config registers to their defaults, phase idle, counters zero.
`timescale 1ns / 1ps

module block_link_receiver_core
    import blr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  blr_in_t     in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output blr_out_t    out_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    blr_cfg_t                   cfg_reg;
    blr_state_t                 state_reg;
    blr_state_t                 state_next;
    logic [1:0]                 step_cnt;
    blr_out_t [MAX_RESULTS-1:0] step_res;
    blr_out_t [MAX_RESULTS-1:0] bnd_res_reg;
    logic [1:0]                 bnd_cnt_reg;
    logic [1:0]                 bnd_idx_reg;
    logic                       pop;
    logic                       pop_last;
    logic                       accept;

    blr_step u_step (
        .cur     (state_reg),
        .cfg     (cfg_reg),
        .item    (in_data),
        .nxt     (state_next),
        .res_cnt (step_cnt),
        .res     (step_res)
    );

    assign cfg_ready = 1'b1;
    assign out_valid = (bnd_cnt_reg != 2'd0);
    assign out_data  = bnd_res_reg[bnd_idx_reg];
    assign pop       = out_valid && out_ready;
    assign pop_last  = pop && (bnd_idx_reg == bnd_cnt_reg - 2'd1);
    assign in_ready  = !out_valid || pop_last;
    assign accept    = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_buffer     <= MAX_BUFFER_RESET;
            cfg_reg.ready_code     <= 8'd0;
            cfg_reg.ready_ack_code <= 8'd0;
            cfg_reg.success_code   <= 8'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_MAX_BUFFER:     cfg_reg.max_buffer     <= cfg_data;
                CFG_READY_CODE:     cfg_reg.ready_code     <= cfg_data[7:0];
                CFG_READY_ACK_CODE: cfg_reg.ready_ack_code <= cfg_data[7:0];
                CFG_SUCCESS_CODE:   cfg_reg.success_code   <= cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase            <= PH_IDLE;
            state_reg.committed_offset <= 16'd0;
            state_reg.expected_index   <= 8'd0;
            state_reg.block_length     <= 16'd0;
            state_reg.payload_count    <= 16'd0;
            state_reg.running_sum      <= 16'd0;
            state_reg.header_code      <= 8'd0;
        end
        else if (accept)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bnd_cnt_reg <= 2'd0;
            bnd_idx_reg <= 2'd0;
        end
        else if (accept)
        begin
            bnd_cnt_reg <= step_cnt;
            bnd_idx_reg <= 2'd0;
        end
        else if (pop_last)
        begin
            bnd_cnt_reg <= 2'd0;
            bnd_idx_reg <= 2'd0;
        end
        else if (pop)
        begin
            bnd_idx_reg <= bnd_idx_reg + 2'd1;
        end
    end

    // hold results until the next word is taken
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            bnd_res_reg <= step_res;
        end
    end

endmodule

// File: rtl/blr_checker.sv
// Port-level assertions for the block link receiver, bound to the top level
`timescale 1ns / 1ps
`include "block_link_receiver_core_assert.svh"

module blr_checker
    import blr_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input blr_out_t    out_data
);

    `BLR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
    `BLR_ASSERT_SAME(a_finish_last, out_valid && out_data.kind == KIND_FINISH, out_data.last)
    `BLR_ASSERT_SAME(a_finish_clean, out_valid && out_data.kind == KIND_FINISH,
                     out_data.value == 8'd0 && out_data.address == 16'd0)
    `BLR_ASSERT_SAME(a_data_no_status, out_valid && out_data.kind != KIND_FINISH,
                     out_data.status == ST_OK && out_data.total_size == 16'd0)
    `BLR_ASSERT_SAME(a_ready_when_empty, !out_valid, in_ready)

endmodule

bind block_link_receiver_core blr_checker u_blr_checker (.*);
